// ===== rtl/core/cbcs_pkg.sv =====
package cbcs_pkg;

  localparam int CH_W      = 10;
  localparam int ACT_W     = 2;
  // Shift of the reciprocal used to split a channel into word and bit
  localparam int DIV_SHIFT = 17;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_TEST    = 2'd1,
    ACT_SEEK_UP = 2'd2,
    ACT_SEEK_DN = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_WMOD,
    ST_TCHK,
    ST_SEEK,
    ST_DONE
  } state_t;

  // Control for the word picker: scan direction and position in the sweep
  typedef struct packed {
    logic down;
    logic first;
    logic last;
  } pick_ctrl_t;

endpackage

// ===== rtl/core/cbcs_if.sv =====
interface cbcs_in_if;
  logic                          valid;
  logic                          ready;
  logic [cbcs_pkg::ACT_W-1:0]    action;
  logic                          list_select;
  logic [cbcs_pkg::CH_W-1:0]     channel_index;
  logic                          flag_value;

  modport source (output valid, action, list_select, channel_index, flag_value,
                  input ready);
  modport sink   (input valid, action, list_select, channel_index, flag_value,
                  output ready);
endinterface

interface cbcs_out_if;
  logic                          valid;
  logic                          ready;
  logic [cbcs_pkg::CH_W-1:0]     result_index;
  logic                          found;
  logic                          index_error;

  modport source (output valid, result_index, found, index_error, input ready);
  modport sink   (input valid, result_index, found, index_error, output ready);
endinterface

// ===== rtl/core/circular_bitmap_channel_seek.sv =====
// One request at a time, taken in the cycle after the previous result is loaded; a
// seek sweeps MAP_WORDS+1 words, one per cycle (MAP_WORDS = ceil(NUM_CHANNELS/WORD_BITS)).
// Reset (synchronous, rst_n low) empties both maps at once through per-word valid
// bits, so no clearing pass is needed and requests are taken straight after reset.
module circular_bitmap_channel_seek #(
  parameter int NUM_CHANNELS = 999,
  parameter int WORD_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  cbcs_in_if.sink     in_req,
  cbcs_out_if.source  out_rsp
);

  localparam int CH_W    = cbcs_pkg::CH_W;
  localparam int WORDS   = (NUM_CHANNELS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int AW      = WA_W + 1;
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int STEP_W  = $clog2(WORDS + 2);
  // Rounded-up reciprocal: exact quotient for every 10-bit channel number
  localparam int RECIP   = ((1 << cbcs_pkg::DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = CH_W + RECIP_W;

  cbcs_pkg::state_t state_r, state_nxt;

  // Request held for the whole operation
  cbcs_pkg::act_t   act_r;
  logic             sel_r;
  logic [CH_W-1:0]  ch_r;
  logic             flag_r;
  logic             bad_r;
  logic [WA_W-1:0]  w0_r;
  logic [BIT_W-1:0] b0_r;

  // Seek sweep: issue side runs one step ahead of the evaluate side
  logic [WA_W-1:0]   iss_w_r;
  logic [STEP_W-1:0] iss_n_r;
  logic [WA_W-1:0]   pend_w_r;
  logic [STEP_W-1:0] pend_n_r;

  logic             found_r;
  logic             use_hit_r;
  logic [WA_W-1:0]  hit_w_r;
  logic [BIT_W-1:0] hit_b_r;

  logic             out_vld_r;
  logic [CH_W-1:0]  out_idx_r;
  logic             out_found_r;
  logic             out_err_r;

  logic                 accept;
  logic                 in_bad;
  logic [PROD_W-1:0]    prod;
  logic [CH_W-1:0]      wbase;
  logic [CH_W-1:0]      hit_ch;
  logic                 seek_down;
  logic [WA_W-1:0]      w0_next;
  logic [WA_W-1:0]      iss_next;

  logic                 mem_re;
  logic [WA_W-1:0]      mem_rword;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  cbcs_pkg::pick_ctrl_t pick_ctrl;
  logic                 pick_hit;
  logic [BIT_W-1:0]     pick_bit;

  logic seek_issue;
  logic take_hit;
  logic ld_out;

  assign accept    = in_req.valid && in_req.ready;
  assign in_bad    = {1'b0, in_req.channel_index} >= (CH_W + 1)'(NUM_CHANNELS);
  // Word number of the requested channel by reciprocal multiplication
  assign prod      = PROD_W'(in_req.channel_index) * PROD_W'(RECIP);
  assign wbase     = CH_W'(w0_r) * CH_W'(WORD_BITS);
  assign hit_ch    = CH_W'(hit_w_r) * CH_W'(WORD_BITS) + CH_W'(hit_b_r);
  assign seek_down = (act_r == cbcs_pkg::ACT_SEEK_DN);

  function automatic logic [WA_W-1:0] step_word(input logic [WA_W-1:0] w,
                                                input logic down);
    logic [WA_W-1:0] r;
    if (down) begin
      r = (w == '0) ? WA_W'(WORDS - 1) : w - 1'b1;
    end else begin
      r = (w == WA_W'(WORDS - 1)) ? '0 : w + 1'b1;
    end
    return r;
  endfunction

  assign w0_next  = step_word(w0_r, seek_down);
  assign iss_next = step_word(iss_w_r, seek_down);

  // Word currently in the read register belongs to step pend_n_r of the sweep
  assign pick_ctrl.down  = seek_down;
  assign pick_ctrl.first = (pend_n_r == '0);
  assign pick_ctrl.last  = (pend_n_r == STEP_W'(WORDS));

  cbcs_word_pick #(
    .WORD_BITS (WORD_BITS),
    .BIT_W     (BIT_W)
  ) u_pick (
    .word      (mem_rdata),
    .start_bit (b0_r),
    .ctrl      (pick_ctrl),
    .hit       (pick_hit),
    .hit_bit   (pick_bit)
  );

  // Replace the addressed flag, keep the rest of the word
  assign mem_wdata = (mem_rdata & ~(WORD_BITS'(1) << b0_r))
                   | (WORD_BITS'(flag_r) << b0_r);

  cbcs_map_mem #(
    .AW (AW),
    .DW (WORD_BITS)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (mem_re),
    .raddr ({sel_r, mem_rword}),
    .we    (mem_we),
    .waddr ({sel_r, w0_r}),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer. Only one request is in flight, so a write-back always lands
  // before the next read of the same word and no forwarding is needed.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    mem_re     = 1'b0;
    mem_rword  = iss_w_r;
    mem_we     = 1'b0;
    seek_issue = 1'b0;
    take_hit   = 1'b0;
    ld_out     = 1'b0;
    unique case (state_r)
      cbcs_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = in_bad ? cbcs_pkg::ST_DONE : cbcs_pkg::ST_SPLIT;
        end
      end
      cbcs_pkg::ST_SPLIT: begin
        // Read the start word for every action
        mem_re    = 1'b1;
        mem_rword = w0_r;
        unique case (act_r)
          cbcs_pkg::ACT_WRITE: state_nxt = cbcs_pkg::ST_WMOD;
          cbcs_pkg::ACT_TEST:  state_nxt = cbcs_pkg::ST_TCHK;
          default:             state_nxt = cbcs_pkg::ST_SEEK;
        endcase
      end
      cbcs_pkg::ST_WMOD: begin
        mem_we    = 1'b1;
        state_nxt = cbcs_pkg::ST_DONE;
      end
      cbcs_pkg::ST_TCHK: begin
        state_nxt = cbcs_pkg::ST_DONE;
      end
      cbcs_pkg::ST_SEEK: begin
        if (iss_n_r <= STEP_W'(WORDS)) begin
          mem_re     = 1'b1;
          seek_issue = 1'b1;
        end
        if (pick_hit) begin
          take_hit  = 1'b1;
          state_nxt = cbcs_pkg::ST_DONE;
        end else if (pick_ctrl.last) begin
          state_nxt = cbcs_pkg::ST_DONE;
        end
      end
      cbcs_pkg::ST_DONE: begin
        if (!out_vld_r || out_rsp.ready) begin
          ld_out    = 1'b1;
          state_nxt = cbcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cbcs_pkg::ST_IDLE;
    endcase
  end

  // Take a new request whenever no operation runs, even with a result waiting
  assign in_req.ready = (state_r == cbcs_pkg::ST_IDLE);

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= cbcs_pkg::act_t'(in_req.action);
      sel_r  <= in_req.list_select;
      ch_r   <= in_req.channel_index;
      flag_r <= in_req.flag_value;
      bad_r  <= in_bad;
      w0_r   <= prod[cbcs_pkg::DIV_SHIFT +: WA_W];
    end
    if (state_r == cbcs_pkg::ST_SPLIT) begin
      b0_r     <= BIT_W'(ch_r - wbase);
      iss_w_r  <= w0_next;
      iss_n_r  <= STEP_W'(1);
      pend_w_r <= w0_r;
      pend_n_r <= '0;
    end else if (seek_issue) begin
      iss_w_r  <= iss_next;
      iss_n_r  <= iss_n_r + 1'b1;
      pend_w_r <= iss_w_r;
      pend_n_r <= iss_n_r;
    end
    if (take_hit) begin
      hit_w_r <= pend_w_r;
      hit_b_r <= pick_bit;
    end
    if (ld_out) begin
      out_idx_r   <= use_hit_r ? hit_ch : ch_r;
      out_found_r <= found_r;
      out_err_r   <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      use_hit_r <= 1'b0;
    end else if (accept) begin
      found_r   <= 1'b0;
      use_hit_r <= 1'b0;
    end else if (state_r == cbcs_pkg::ST_TCHK) begin
      found_r   <= mem_rdata[b0_r];
    end else if (take_hit) begin
      found_r   <= 1'b1;
      use_hit_r <= 1'b1;
    end
  end

  // Output register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ld_out) begin
      out_vld_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_rsp.valid        = out_vld_r;
  assign out_rsp.result_index = out_idx_r;
  assign out_rsp.found        = out_found_r;
  assign out_rsp.index_error  = out_err_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_err_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_found_r && out_err_r))
    else $error("result flags both found and index error");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_found_r) |-> ({1'b0, out_idx_r} < (CH_W + 1)'(NUM_CHANNELS)))
    else $error("found channel beyond channel count");

  a_bad_skips_maps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_bad) |=> (state_r == cbcs_pkg::ST_DONE))
    else $error("out-of-range request entered map access");

  a_no_bad_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !bad_r)
    else $error("map written for out-of-range channel");

  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cbcs_pkg::ST_SEEK) |-> (pend_n_r + 1'b1 == iss_n_r))
    else $error("seek issue and evaluate steps out of step");

endmodule

// ===== rtl/core/cbcs_map_mem.sv =====
module cbcs_map_mem #(
  parameter int AW = 6,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0]     mem [2**AW];
  logic [2**AW-1:0]  vld_r;
  logic [DW-1:0]     q_r;
  logic              q_vld_r;

  // A word never written reads as all zeros
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q_r     <= mem[raddr];
      q_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = q_vld_r ? q_r : '0;

endmodule

// ===== rtl/core/cbcs_word_pick.sv =====
module cbcs_word_pick #(
  parameter int WORD_BITS = 32,
  parameter int BIT_W     = 5
) (
  input  logic [WORD_BITS-1:0]  word,
  input  logic [BIT_W-1:0]      start_bit,
  input  cbcs_pkg::pick_ctrl_t  ctrl,
  output logic                  hit,
  output logic [BIT_W-1:0]      hit_bit
);

  logic [WORD_BITS-1:0] ge;
  logic [WORD_BITS-1:0] gt;
  logic [WORD_BITS-1:0] m;

  always_comb begin
    ge = {WORD_BITS{1'b1}} << start_bit;
    gt = ge << 1;
    m  = word;
    if (ctrl.down) begin
      if (ctrl.first) begin
        m = word & ~ge;
      end else if (ctrl.last) begin
        m = word & ge;
      end
    end else begin
      if (ctrl.first) begin
        m = word & gt;
      end else if (ctrl.last) begin
        m = word & ~gt;
      end
    end
  end

  // Upward takes the lowest set bit, downward the highest
  always_comb begin
    hit     = |m;
    hit_bit = '0;
    if (ctrl.down) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (m[i]) hit_bit = BIT_W'(i);
      end
    end else begin
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
        if (m[i]) hit_bit = BIT_W'(i);
      end
    end
  end

endmodule

// ===== tb/circular_bitmap_channel_seek_test.sv =====
`timescale 1ns / 1ps

module circular_bitmap_channel_seek_test;

  // Block geometry; must match the parameters handed to u_dut
  localparam int NUM_CH         = 999;
  localparam int MAP_WORD_BITS  = 32;
  // Random requests per idling mix, and in the hold-off stretch
  localparam int MIX_REQUESTS   = 440;
  localparam int HOLD_REQUESTS  = 100;
  // Receiver hold-off length, counted in clock cycles
  localparam int HOLD_CYCLES    = 400;
  // Allow generous slack after the last result
  localparam int DRAIN_CYCLES   = 64;
  // Cycles without any handshake before the run is abandoned
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [cbcs_pkg::CH_W-1:0] result_index;
    logic                      found;
    logic                      index_error;
  } chan_result_t;

  // Mirror of the two flag maps; works out the answer to each accepted request and
  // holds it until the block's result turns up.
  class chan_map_scoreboard;
    bit           flags [2][NUM_CH];
    chan_result_t due_q [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  n_write, n_test, n_seek, n_hit, n_range;

    function void note_request(cbcs_pkg::act_t act, bit sel,
                               bit [cbcs_pkg::CH_W-1:0] ch, bit val);
      chan_result_t r;
      int           pos;
      bit           bad;
      bad            = (ch >= NUM_CH);
      r.result_index = ch;
      r.found        = 1'b0;
      r.index_error  = bad;
      if (bad) begin
        n_range++;
      end else begin
        case (act)
          cbcs_pkg::ACT_WRITE: begin
            n_write++;
            flags[sel][ch] = val;
          end
          cbcs_pkg::ACT_TEST: begin
            n_test++;
            r.found = flags[sel][ch];
          end
          default: begin
            // Visit every channel once, starting beside the given one and
            // finishing on the given channel itself
            n_seek++;
            pos = ch;
            for (int n = 0; n < NUM_CH && !r.found; n++) begin
              if (act == cbcs_pkg::ACT_SEEK_UP) begin
                pos = (pos + 1 >= NUM_CH) ? 0 : pos + 1;
              end else begin
                pos = (pos == 0) ? NUM_CH - 1 : pos - 1;
              end
              if (flags[sel][pos]) begin
                r.found        = 1'b1;
                r.result_index = cbcs_pkg::CH_W'(pos);
              end
            end
            if (r.found) n_hit++;
          end
        endcase
      end
      due_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      $display("mismatch on %s at result %0d: got %0d, want %0d",
               what, checked, got, want);
    endtask

    task check_result(chan_result_t got);
      chan_result_t want;
      if (due_q.size() == 0) begin
        report_mismatch("result with no request outstanding", got.result_index, 0);
      end else begin
        want = due_q.pop_front();
        checked++;
        if (got.result_index !== want.result_index)
          report_mismatch("result_index", got.result_index, want.result_index);
        if (got.found !== want.found)
          report_mismatch("found", got.found, want.found);
        if (got.index_error !== want.index_error)
          report_mismatch("index_error", got.index_error, want.index_error);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  cbcs_in_if  in_req ();
  cbcs_out_if out_rsp ();

  circular_bitmap_channel_seek #(
    .NUM_CHANNELS (NUM_CH),
    .WORD_BITS    (MAP_WORD_BITS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #2 clk = ~clk;

  chan_map_scoreboard sb;

  // Idling knobs, changed by the main sequence between mixes
  int send_idle_pct;
  int recv_stall_pct;
  int fill_pct;
  int win_base;
  int hold_until;
  int cycle_no     = 0;
  int quiet_cycles = 0;

  // Receiver: check each accepted result, then pick the next ready value.
  // Hold ready low while a hold-off is in force so the block backs up.
  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready)
      sb.check_result('{out_rsp.result_index, out_rsp.found, out_rsp.index_error});
    if (!rst_n || cycle_no < hold_until) begin
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: abandon the run once no handshake has happened for too long
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results still due",
               quiet_cycles, sb.due_q.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, idling first at the sender's rate; return at the edge where
  // it is taken. Leave valid high so a back-to-back request follows without a gap.
  task automatic send_request(cbcs_pkg::act_t act, bit sel,
                              bit [cbcs_pkg::CH_W-1:0] ch, bit val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.action        <= act;
    in_req.list_select   <= sel;
    in_req.channel_index <= ch;
    in_req.flag_value    <= val;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sb.note_request(act, sel, ch, val);
  endtask

  // Random request: bias channels towards both ends of the map, a moving window
  // (so seeks land among recently written flags) and the out-of-range tail.
  task automatic send_random();
    int                      r;
    cbcs_pkg::act_t          act;
    bit [cbcs_pkg::CH_W-1:0] ch;
    bit                      val;
    r = $urandom_range(99);
    if (r < 38)      act = cbcs_pkg::ACT_WRITE;
    else if (r < 55) act = cbcs_pkg::ACT_TEST;
    else if (r < 78) act = cbcs_pkg::ACT_SEEK_UP;
    else             act = cbcs_pkg::ACT_SEEK_DN;
    r = $urandom_range(99);
    if (r < 45)
      ch = cbcs_pkg::CH_W'($urandom_range(NUM_CH - 1));
    else if (r < 65)
      ch = $urandom_range(1) ? cbcs_pkg::CH_W'($urandom_range(7))
                             : cbcs_pkg::CH_W'(NUM_CH - 1 - $urandom_range(7));
    else if (r < 80)
      ch = cbcs_pkg::CH_W'((win_base + $urandom_range(15)) % NUM_CH);
    else if (r < 92)
      ch = cbcs_pkg::CH_W'($urandom_range(1023, NUM_CH));
    else
      ch = cbcs_pkg::CH_W'($urandom_range(1023));
    // Writes set flags at the current fill rate; other actions ignore the value
    if (act == cbcs_pkg::ACT_WRITE) val = ($urandom_range(99) < fill_pct);
    else                            val = 1'($urandom_range(1));
    send_request(act, 1'($urandom_range(1)), ch, val);
  endtask

  int idle_mix  [4] = '{0, 85, 0, 35};
  int stall_mix [4] = '{0, 0, 85, 35};
  int fill_mix  [4] = '{50, 15, 70, 5};

  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fill_pct       = 30;
    win_base       = 0;
    hold_until     = 0;

    rst_n                <= 1'b0;
    in_req.valid         <= 1'b0;
    in_req.action        <= cbcs_pkg::ACT_WRITE;
    in_req.list_select   <= 1'b0;
    in_req.channel_index <= '0;
    in_req.flag_value    <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty maps straight after reset: test misses, seeks find nothing
    send_request(cbcs_pkg::ACT_TEST,    1'b0, 10'd0,    1'b1);
    send_request(cbcs_pkg::ACT_SEEK_UP, 1'b0, 10'd0,    1'b0);
    send_request(cbcs_pkg::ACT_SEEK_DN, 1'b1, 10'd998,  1'b1);
    // Flags at both ends: seeks wrap across the top and from channel zero down
    send_request(cbcs_pkg::ACT_WRITE,   1'b0, 10'd0,    1'b1);
    send_request(cbcs_pkg::ACT_WRITE,   1'b0, 10'd998,  1'b1);
    send_request(cbcs_pkg::ACT_SEEK_DN, 1'b0, 10'd0,    1'b0);
    send_request(cbcs_pkg::ACT_SEEK_UP, 1'b0, 10'd998,  1'b0);
    send_request(cbcs_pkg::ACT_SEEK_UP, 1'b0, 10'd0,    1'b0);
    send_request(cbcs_pkg::ACT_TEST,    1'b0, 10'd998,  1'b0);
    // Only channel 500 set in the scan map: seeks from it return 500 itself
    send_request(cbcs_pkg::ACT_WRITE,   1'b1, 10'd500,  1'b1);
    send_request(cbcs_pkg::ACT_SEEK_UP, 1'b1, 10'd500,  1'b0);
    send_request(cbcs_pkg::ACT_SEEK_DN, 1'b1, 10'd500,  1'b1);
    send_request(cbcs_pkg::ACT_SEEK_DN, 1'b1, 10'd501,  1'b0);
    // Out-of-range channels: flagged, writes dropped, no scan
    send_request(cbcs_pkg::ACT_WRITE,   1'b0, 10'd999,  1'b1);
    send_request(cbcs_pkg::ACT_TEST,    1'b0, 10'd999,  1'b1);
    send_request(cbcs_pkg::ACT_SEEK_UP, 1'b0, 10'd1023, 1'b1);
    send_request(cbcs_pkg::ACT_SEEK_DN, 1'b1, 10'd1023, 1'b0);
    send_request(cbcs_pkg::ACT_WRITE,   1'b1, 10'd1023, 1'b0);
    // Clear a flag and confirm; then a lone flag under a downward seek from zero
    send_request(cbcs_pkg::ACT_WRITE,   1'b0, 10'd998,  1'b0);
    send_request(cbcs_pkg::ACT_TEST,    1'b0, 10'd998,  1'b1);
    send_request(cbcs_pkg::ACT_SEEK_DN, 1'b0, 10'd0,    1'b1);
    // Flags either side of a word boundary
    send_request(cbcs_pkg::ACT_WRITE,   1'b1, 10'd31,   1'b1);
    send_request(cbcs_pkg::ACT_SEEK_UP, 1'b1, 10'd0,    1'b0);
    send_request(cbcs_pkg::ACT_WRITE,   1'b1, 10'd32,   1'b1);
    send_request(cbcs_pkg::ACT_SEEK_DN, 1'b1, 10'd500,  1'b0);

    // Random traffic under each idling mix, moving the window every 40 requests
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = idle_mix[m];
      recv_stall_pct = stall_mix[m];
      fill_pct       = fill_mix[m];
      for (int i = 0; i < MIX_REQUESTS; i++) begin
        if (i % 40 == 0) win_base = $urandom_range(NUM_CH - 1);
        send_random();
      end
    end

    // Hold the receiver off while the sender keeps offering, so the block backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fill_pct       = 30;
    hold_until     = cycle_no + HOLD_CYCLES;
    repeat (HOLD_REQUESTS) send_random();
    in_req.valid <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.due_q.size() != 0)
      sb.report_mismatch("results never delivered", sb.due_q.size(), 0);

    $display("covered %0d requests: %0d writes, %0d tests, %0d seeks (%0d hits), %0d bad",
             sb.n_write + sb.n_test + sb.n_seek + sb.n_range,
             sb.n_write, sb.n_test, sb.n_seek, sb.n_hit, sb.n_range);
    $display("four idling mixes, a %0d-cycle hold-off; %0d checked, %0d mismatches",
             HOLD_CYCLES, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cbcs_pkg.sv
rtl/core/cbcs_if.sv
rtl/core/cbcs_map_mem.sv
rtl/core/cbcs_word_pick.sv
rtl/core/circular_bitmap_channel_seek.sv
tb/circular_bitmap_channel_seek_test.sv
